### rtl/cev_pkg.sv
package cev_pkg;

    // Frame size bounds and field widths.
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int SIZE_W      = 11;
    localparam int POS_W       = 10;
    localparam int EXT_W       = 11;
    localparam int CFG_INDEX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Reset values of the size registers.
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd80;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd24;

    // Checksum constants.
    localparam logic [31:0] CRC_POLY  = 32'h82F63B78;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

    // Hash request queue depth.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Stream widths.
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 104;

    // One hash request from the front part to the back part.
    typedef struct packed {
        logic             has_max;
        logic [EXT_W-1:0] max_val;
        logic             has_col;
        logic [EXT_W-1:0] col_val;
        logic             last;
        logic             match;
        logic [31:0]      crc;
    } fnv_req_t;

    // Clamps a configured size into 1 .. hi.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = {{(SIZE_W-1){1'b0}}, 1'b1};
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    // Reflected CRC32C over a whole 64-bit word, low byte first (XOR network).
    function automatic logic [31:0] crc_word(input logic [31:0] crc_in,
                                             input logic [63:0] w);
        logic [31:0] c;
        c = crc_in;
        for (int b = 0; b < 64; b++)
        begin
            c = (c[0] ^ w[b]) ? ({1'b0, c[31:1]} ^ CRC_POLY) : {1'b0, c[31:1]};
        end
        return c;
    endfunction

    // Multiply by the FNV-1a 64 prime, 2^40 + 0x1B3, as a sum of shifts.
    function automatic logic [63:0] fnv_mul(input logic [63:0] x);
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

### rtl/canvas_extent_verifier.sv
// Accepts one cell per cycle while the hash request queue is not full; the CRC and
// extent checks keep pace in the front part. Each row end and each frame's first cell
// queue a 4-byte FNV-1a step (8 bytes when both) in the back part, one byte per cycle
// unless a result waits for the output; rows narrower than about 4 cells slow intake.
// rst_n clears all frame state, the queue and the output; sizes reset to 80 by 24.
module canvas_extent_verifier
    import cev_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]      cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: cell_word[63:0], cached_last_col[74:64], cached_max_row[85:75].
    input  logic [IN_DATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: caches_match[0], cell_hash[32:1], cache_hash[96:33].
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    fnv_req_t q_in;
    fnv_req_t q_out;

    assign cfg_ready = 1'b1;

    // Front part: counters, CRC and extent checks.
    cev_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (s_tvalid),
        .cell_word       (s_tdata[63:0]),
        .cached_last_col (s_tdata[74:64]),
        .cached_max_row  (s_tdata[85:75]),
        .q_full          (q_full),
        .in_ready        (s_tready),
        .q_push          (q_push),
        .q_data          (q_in)
    );

    // Hash request queue.
    cev_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // Back part: FNV hash and result output.
    cev_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

### rtl/cev_queue.sv
module cev_queue
    import cev_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  fnv_req_t push_data,
    output logic     full,
    input  logic     pop,
    output fnv_req_t pop_data,
    output logic     empty
);

    fnv_req_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg;
    logic [QUEUE_AW-1:0]     rd_ptr_reg;
    logic [QUEUE_AW:0]       count_reg;
    logic [QUEUE_AW:0]       count_next;

    assign full     = (count_reg == QUEUE_DEPTH[QUEUE_AW:0]);
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Occupancy follows push and pop.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/cev_front.sv
module cev_front
    import cev_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]      cfg_data,
    input  logic                   in_valid,
    input  logic [63:0]            cell_word,
    input  logic [EXT_W-1:0]       cached_last_col,
    input  logic [EXT_W-1:0]       cached_max_row,
    input  logic                   q_full,
    output logic                   in_ready,
    output logic                   q_push,
    output fnv_req_t               q_data
);

    logic [SIZE_W-1:0]        width_reg;
    logic [SIZE_W-1:0]        height_reg;
    logic [31:0]              crc_reg;
    logic [31:0]              crc_next;
    logic [POS_W-1:0]         col_reg;
    logic [POS_W-1:0]         row_reg;
    logic signed [EXT_W-1:0]  row_last_reg;
    logic signed [EXT_W-1:0]  row_last_next;
    logic signed [EXT_W-1:0]  true_max_reg;
    logic signed [EXT_W-1:0]  true_max_next;
    logic signed [EXT_W-1:0]  claim_max_reg;
    logic signed [EXT_W-1:0]  claim_max_next;
    logic                     mismatch_reg;
    logic                     mismatch_next;
    logic [SIZE_W-1:0]        width_eff;
    logic [SIZE_W-1:0]        height_eff;
    logic                     accept;
    logic                     first_cell;
    logic                     row_end;
    logic                     frame_end;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Classify the current cell by position.
    always_comb
    begin
        width_eff  = clamp_size(width_reg, MAX_WIDTH[SIZE_W-1:0]);
        height_eff = clamp_size(height_reg, MAX_HEIGHT[SIZE_W-1:0]);
        first_cell = (col_reg == '0) && (row_reg == '0);
        row_end    = ({1'b0, col_reg} + 1'b1) >= width_eff;
        frame_end  = row_end && (({1'b0, row_reg} + 1'b1) >= height_eff);
    end

    // Extent tracking and comparison for one cell.
    always_comb
    begin
        crc_next       = crc_word(crc_reg, cell_word);
        claim_max_next = first_cell ? $signed(cached_max_row) : claim_max_reg;
        row_last_next  = (cell_word != '0) ? $signed({1'b0, col_reg}) : row_last_reg;
        true_max_next  = true_max_reg;
        mismatch_next  = mismatch_reg;
        if (row_end)
        begin
            if ($signed(cached_last_col) != row_last_next)
            begin
                mismatch_next = 1'b1;
            end
            if (row_last_next >= 0)
            begin
                true_max_next = $signed({1'b0, row_reg});
            end
        end
        if (frame_end && (claim_max_next != true_max_next))
        begin
            mismatch_next = 1'b1;
        end
    end

    // Hash request for the back part.
    always_comb
    begin
        q_push          = accept && (first_cell || row_end);
        q_data.has_max  = first_cell;
        q_data.max_val  = cached_max_row;
        q_data.has_col  = row_end;
        q_data.col_val  = cached_last_col;
        q_data.last     = frame_end;
        q_data.match    = !mismatch_next;
        q_data.crc      = crc_next;
    end

    // Size registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Frame state; it returns to reset values at frame end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            row_last_reg  <= '1;
            true_max_reg  <= '1;
            claim_max_reg <= '1;
            mismatch_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                crc_reg       <= CRC_INIT;
                col_reg       <= '0;
                row_reg       <= '0;
                row_last_reg  <= '1;
                true_max_reg  <= '1;
                claim_max_reg <= '1;
                mismatch_reg  <= 1'b0;
            end
            else
            begin
                crc_reg       <= crc_next;
                claim_max_reg <= claim_max_next;
                true_max_reg  <= true_max_next;
                mismatch_reg  <= mismatch_next;
                if (row_end)
                begin
                    col_reg      <= '0;
                    row_reg      <= row_reg + 1'b1;
                    row_last_reg <= '1;
                end
                else
                begin
                    col_reg      <= col_reg + 1'b1;
                    row_last_reg <= row_last_next;
                end
            end
        end
    end

endmodule

### rtl/cev_back.sv
module cev_back
    import cev_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  fnv_req_t              q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    fnv_req_t              cur_reg;
    logic                  busy_reg;
    logic [2:0]            idx_reg;
    logic [63:0]           fnv_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [63:0]           ext_word;
    logic [7:0]            cur_byte;
    logic [63:0]           fnv_new;
    logic [2:0]            idx_end;
    logic [2:0]            idx_start;
    logic                  at_end;
    logic                  out_free;
    logic                  step_ok;
    logic                  finish;

    // One byte of the sign-extended claims is folded in per cycle unless a result waits.
    always_comb
    begin
        ext_word  = {{(32-EXT_W){cur_reg.col_val[EXT_W-1]}}, cur_reg.col_val,
                     {(32-EXT_W){cur_reg.max_val[EXT_W-1]}}, cur_reg.max_val};
        cur_byte  = ext_word[{idx_reg, 3'b000} +: 8];
        fnv_new   = fnv_mul(fnv_reg ^ {56'd0, cur_byte});
        idx_end   = cur_reg.has_col ? 3'd7 : 3'd3;
        idx_start = q_data.has_max ? 3'd0 : 3'd4;
        at_end    = (idx_reg == idx_end);
        out_free  = !out_valid_reg || out_ready;
        step_ok   = busy_reg && (!(at_end && cur_reg.last) || out_free);
        finish    = step_ok && at_end;
        q_pop     = !q_empty && (!busy_reg || finish);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Sequencer and hash accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            fnv_reg  <= FNV_BASIS;
        end
        else
        begin
            if (step_ok)
            begin
                fnv_reg <= (finish && cur_reg.last) ? FNV_BASIS : fnv_new;
            end
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= idx_start;
            end
            else
            begin
                if (finish)
                begin
                    busy_reg <= 1'b0;
                end
                if (step_ok)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    // Current request register.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish && cur_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish && cur_reg.last)
        begin
            out_data_reg <= {7'd0, fnv_new, cur_reg.crc, cur_reg.match};
        end
    end

endmodule

### dv/frame_result_check.sv
module frame_result_check
    import cev_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]      cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // Fields from bit 0: cell_word[63:0], cached_last_col[74:64], cached_max_row[85:75].
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: caches_match[0], cell_hash[32:1], cache_hash[96:33].
    input  logic [OUT_DATA_W-1:0]  m_tdata,
    output int                     fail_count,
    output int                     results_checked,
    output int                     results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;

    // What one frame should report at its end.
    typedef struct {
        bit          ok;
        logic [31:0] crc;
        logic [63:0] fnv;
    } frame_sum_t;

    frame_sum_t sums_due[$];

    // Our own copy of the size registers and of the per-frame state.
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [31:0]       crc_run;
    logic [63:0]       fnv_run;
    int                col_at;
    int                row_at;
    int                row_last_set;
    int                max_row_seen;
    int                max_row_claim;
    bit                any_miss;
    int                errs = 0;
    int                checked = 0;

    // Reflected CRC32C over one 64-bit word, low byte first.
    function automatic logic [31:0] crc32c_word(input logic [31:0] acc, input logic [63:0] word);
        logic [31:0] c;
        c = acc;
        for (int i = 0; i < 8; i++)
        begin
            c = c ^ {24'd0, word[8*i +: 8]};
            for (int k = 0; k < 8; k++)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
        end
        return c;
    endfunction

    // FNV-1a 64 over one 32-bit integer, low byte first.
    function automatic logic [63:0] fnv_fold_int(input logic [63:0] h, input int v);
        logic [63:0] x;
        logic [31:0] u;
        x = h;
        u = v;
        for (int b = 0; b < 4; b++)
        begin
            x = (x ^ {56'd0, u[8*b +: 8]}) * FNV_PRIME;
        end
        return x;
    endfunction

    // A size of zero counts as one; anything above the bound counts as the bound.
    function automatic int size_bound(input logic [SIZE_W-1:0] v, input int hi);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > hi)
        begin
            return hi;
        end
        return int'(v);
    endfunction

    task automatic frame_restart();
        crc_run       = CRC_INIT;
        fnv_run       = FNV_BASIS;
        col_at        = 0;
        row_at        = 0;
        row_last_set  = -1;
        max_row_seen  = -1;
        max_row_claim = -1;
        any_miss      = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
        errs++;
    endtask

    // Compare one accepted frame result with the oldest expectation.
    task automatic compare_result(input logic [OUT_DATA_W-1:0] d);
        frame_sum_t e;
        if (sums_due.size() == 0)
        begin
            report_mismatch("result with no frame ended, cache_hash", d[96:33], 64'd0);
            return;
        end
        e = sums_due.pop_front();
        if (d[0] != e.ok)
        begin
            report_mismatch("caches_match", 64'(d[0]), 64'(e.ok));
        end
        if (d[32:1] != e.crc)
        begin
            report_mismatch("cell_hash", 64'(d[32:1]), 64'(e.crc));
        end
        if (d[96:33] != e.fnv)
        begin
            report_mismatch("cache_hash", d[96:33], e.fnv);
        end
        checked++;
    endtask

    // Advance the frame state by one accepted cell request.
    task automatic predict_cell(input logic [IN_DATA_W-1:0] d);
        int                      w;
        int                      h;
        int                      col_claim;
        logic signed [EXT_W-1:0] field;
        logic [63:0]             cell_val;
        w        = size_bound(width_reg, MAX_WIDTH);
        h        = size_bound(height_reg, MAX_HEIGHT);
        cell_val = d[63:0];

        // The maximum-row claim is taken from the frame's first cell only.
        if (col_at == 0 && row_at == 0)
        begin
            field         = d[64+EXT_W +: EXT_W];
            max_row_claim = field;
            fnv_run       = fnv_fold_int(fnv_run, max_row_claim);
        end

        crc_run = crc32c_word(crc_run, cell_val);
        if (cell_val != '0)
        begin
            row_last_set = col_at;
        end
        if (col_at + 1 < w)
        begin
            col_at++;
            return;
        end

        // Row end: the column claim is checked and hashed.
        field     = d[64 +: EXT_W];
        col_claim = field;
        fnv_run   = fnv_fold_int(fnv_run, col_claim);
        if (col_claim != row_last_set)
        begin
            any_miss = 1'b1;
        end
        if (row_last_set >= 0)
        begin
            max_row_seen = row_at;
        end
        row_last_set = -1;
        col_at       = 0;
        if (row_at + 1 < h)
        begin
            row_at++;
            return;
        end

        // Frame end.
        if (max_row_claim != max_row_seen)
        begin
            any_miss = 1'b1;
        end
        sums_due.push_back('{!any_miss, crc_run, fnv_run});
        frame_restart();
    endtask

    // Results are compared before the cell of the same edge is folded in.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            frame_restart();
            sums_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg = cfg_data;
                    REG_FRAME_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                compare_result(m_tdata);
            end
            if (s_tvalid && s_tready)
            begin
                predict_cell(s_tdata);
            end
        end
        fail_count      <= errs;
        results_checked <= checked;
        results_pending <= sums_due.size();
    end

endmodule

### dv/tb.sv
module tb
    import cev_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_CELLS  = 90;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd2;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]      cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;

    int fail_count;
    int results_checked;
    int results_pending;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int cur_w          = int'(WIDTH_RESET);
    int cur_h          = int'(HEIGHT_RESET);
    int pos_col        = 0;
    int pos_row        = 0;
    int cells_sent     = 0;
    int size_settings  = 0;

    canvas_extent_verifier uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    frame_result_check result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .results_checked (results_checked),
        .results_pending (results_pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any handshake.
    initial
    begin
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("Run stalled for %0d cycles with %0d frames outstanding.",
                 IDLE_LIMIT, results_pending);
        $display("FAILURE");
        $finish;
    end

    function automatic int bounded(input int v, input int hi);
        if (v < 1)
        begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_cell(input logic [63:0] cell_val,
                                                       input logic [EXT_W-1:0] col_claim,
                                                       input logic [EXT_W-1:0] row_claim);
        return {{(IN_DATA_W-64-2*EXT_W){1'b0}}, row_claim, col_claim, cell_val};
    endfunction

    // Blank cells a third of the time, with single bits, all ones and full random words.
    function automatic logic [63:0] random_cell();
        logic [63:0] v;
        case ($urandom_range(5))
            0, 1:    v = 64'd0;
            2:       v = 64'd1 << $urandom_range(63);
            3:       v = '1;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [EXT_W-1:0] claim_of(input int truth, input int fault_pct);
        if ($urandom_range(99) < fault_pct)
        begin
            return EXT_W'($urandom);
        end
        return EXT_W'(truth);
    endfunction

    task automatic set_mode(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default:   begin send_idle_pct = 6;  recv_stall_pct = 6;  end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_size(input int w, input int h);
        write_reg(REG_FRAME_WIDTH, SIZE_W'(w));
        write_reg(REG_FRAME_HEIGHT, SIZE_W'(h));
        cur_w = bounded(w, MAX_WIDTH);
        cur_h = bounded(h, MAX_HEIGHT);
        size_settings++;
    endtask

    // Offer one cell request, with an optional random gap first.
    task automatic push_cell(input logic [IN_DATA_W-1:0] d);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {2'b00, 22'($urandom), $urandom, $urandom};
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        cells_sent++;

        // Track where the block stands in its frame.
        if (pos_col + 1 < cur_w)
        begin
            pos_col++;
        end
        else
        begin
            pos_col = 0;
            pos_row = (pos_row + 1 < cur_h) ? pos_row + 1 : 0;
        end
    endtask

    // One whole frame with mostly true claims and junk in the unused claim fields.
    task automatic send_frame(input int fault_pct);
        logic [63:0]      cells[$];
        int               row_end[$];
        int               top_row;
        int               lc;
        bit               blank_frame;
        bit               blank_row;
        logic [63:0]      cw;
        logic [EXT_W-1:0] cc;
        logic [EXT_W-1:0] mc;
        top_row     = -1;
        blank_frame = ($urandom_range(9) == 0);
        for (int r = 0; r < cur_h; r++)
        begin
            blank_row = blank_frame || ($urandom_range(99) < 30);
            lc = -1;
            for (int c = 0; c < cur_w; c++)
            begin
                cw = blank_row ? 64'd0 : random_cell();
                if (cw != '0)
                begin
                    lc = c;
                end
                cells.push_back(cw);
            end
            row_end.push_back(lc);
            if (lc >= 0)
            begin
                top_row = r;
            end
        end
        for (int i = 0; i < cells.size(); i++)
        begin
            cc = EXT_W'($urandom);
            mc = EXT_W'($urandom);
            if (i % cur_w == cur_w - 1)
            begin
                cc = claim_of(row_end[i / cur_w], fault_pct);
            end
            if (i == 0)
            begin
                mc = claim_of(top_row, fault_pct);
            end
            push_cell(pack_cell(cells[i], cc, mc));
        end
    endtask

    // Random cells and claims until the block is back at a frame start.
    task automatic finish_frame();
        while (pos_col != 0 || pos_row != 0)
        begin
            push_cell(pack_cell(random_cell(), EXT_W'($urandom), EXT_W'($urandom)));
        end
    endtask

    // Stop offering, wait for every frame result, then let the hash stage drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (results_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int mark;
        int w;
        int h;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A frame opened at the reset size, then cut short by a shrink to one cell.
        set_mode(IDLE_NONE);
        repeat (3) push_cell(pack_cell(random_cell(), EXT_W'($urandom), EXT_W'($urandom)));
        settle();
        set_size(0, 0);
        write_reg(REG_UNUSED, '1);
        push_cell(pack_cell(64'd0, EXT_W'(-1), EXT_W'(-1)));

        // One-cell frames: blank, full, and claims that no true extent can equal.
        push_cell(pack_cell(64'd0, EXT_W'(-1), EXT_W'(-1)));
        push_cell(pack_cell('1, EXT_W'(0), EXT_W'(0)));
        push_cell(pack_cell(64'h8000_0000_0000_0000, EXT_W'(1023), EXT_W'(-1024)));
        push_cell(pack_cell(64'd0, EXT_W'(-1), EXT_W'(0)));
        settle();

        // 3x2 frame with content in row 0 only, all claims right.
        set_size(3, 2);
        push_cell(pack_cell(64'd0, EXT_W'($urandom), EXT_W'(0)));
        push_cell(pack_cell(64'd1, EXT_W'($urandom), EXT_W'($urandom)));
        push_cell(pack_cell(64'd0, EXT_W'(1), EXT_W'($urandom)));
        push_cell(pack_cell(64'd0, EXT_W'($urandom), EXT_W'($urandom)));
        push_cell(pack_cell(64'd0, EXT_W'($urandom), EXT_W'($urandom)));
        push_cell(pack_cell(64'd0, EXT_W'(-1), EXT_W'($urandom)));

        // 3x2 frame with a wrong column claim on an empty row.
        push_cell(pack_cell(64'd0, EXT_W'($urandom), EXT_W'(1)));
        push_cell(pack_cell(64'd0, EXT_W'($urandom), EXT_W'($urandom)));
        push_cell(pack_cell(64'd0, EXT_W'(2), EXT_W'($urandom)));
        push_cell(pack_cell(64'd0, EXT_W'($urandom), EXT_W'($urandom)));
        push_cell(pack_cell(64'd0, EXT_W'($urandom), EXT_W'($urandom)));
        push_cell(pack_cell('1, EXT_W'(2), EXT_W'($urandom)));

        // Narrow the rows while the column position is already past the new edge.
        push_cell(pack_cell(64'd5, EXT_W'($urandom), EXT_W'(0)));
        push_cell(pack_cell(64'd0, EXT_W'($urandom), EXT_W'($urandom)));
        settle();
        set_size(2, 2);
        finish_frame();
        settle();

        // Random phases of small frames, some left open across a size change.
        for (int p = 0; p < 8; p++)
        begin
            set_mode(idle_mode_t'(p % 4));
            if (p % 3 == 2)
            begin
                w = $urandom_range(9, 40);
                h = $urandom_range(1, 3);
            end
            else
            begin
                w = $urandom_range(0, 8);
                h = $urandom_range(0, 6);
            end
            set_size(w, h);
            finish_frame();
            mark = cells_sent;
            while (cells_sent - mark < PHASE_CELLS)
            begin
                send_frame($urandom_range(1) ? 0 : $urandom_range(5, 40));
            end
            if (p != 7 && $urandom_range(1) == 1)
            begin
                repeat ($urandom_range(1, 4))
                    push_cell(pack_cell(random_cell(), EXT_W'($urandom), EXT_W'($urandom)));
            end
            settle();
        end

        // Long hold-off on the result side while one-cell frames keep coming.
        set_mode(IDLE_NONE);
        set_size(1, 1);
        hold_left = HOLD_CYCLES;
        repeat (40) send_frame($urandom_range(0, 30));
        settle();

        // Size bound: a width above the limit gives one row at the full clamped width.
        set_mode(IDLE_BOTH);
        set_size(2047, 1);
        send_frame(10);
        settle();

        $display("Covered %0d cells and %0d frame results over %0d size settings,",
                 cells_sent, results_checked, size_settings);
        $display("with idle and stall mixes, mid-frame resizes, size bounds and a long hold-off.");
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
